/* design/ctlc_pkg.sv */
// Shared types, codes and defaults of the centroid tracker line counter.
`default_nettype none
package ctlc_pkg;

  localparam int unsigned TRACK_SLOTS_DEF = 32;
  localparam int unsigned FRAME_DET_DEF   = 32;
  localparam int unsigned COORD_BITS_DEF  = 12;

  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_LINE       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MISSED = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS     = 2'd2;

  localparam logic [11:0] LINE_RST   = 12'd320;
  localparam logic [7:0]  MISSED_RST = 8'd30;
  localparam logic [11:0] RADIUS_RST = 12'd50;

  localparam logic [7:0] MISSED_MAX   = 8'd255;
  localparam logic [7:0] PERSON_CLASS = 8'd0;

  typedef enum logic [1:0] {
    ACT_DETECT    = 2'd0,
    ACT_FRAME_END = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_UNUSED    = 2'd3
  } action_e;

  typedef struct packed {
    logic det_load;
    logic clear_all;
    logic frame_start;
    logic min_rd;
    logic min_cmp;
    logic match_start;
    logic mt_rec;
    logic c_rd;
    logic c_diff;
    logic c_mul;
    logic c_cmp;
    logic mt_wb;
    logic nw_init;
    logic nw_rd;
    logic nw_free;
    logic cr_rd;
    logic cr_chk;
    logic result_load;
  } ctlc_cmd_t;

  typedef struct packed {
    logic best_found;
    logic idx_last;
    logic cand_end;
    logic cand_taken;
    logic slot_full;
    logic slot_free;
    logic out_free;
  } ctlc_status_t;

endpackage
`default_nettype wire

/* design/ctlc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module ctlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/ctlc_datapath.sv */
// Datapath: candidate and track stores, distance arithmetic, counters and result register.
`default_nettype none
module ctlc_datapath #(
  parameter int unsigned TrackSlots = ctlc_pkg::TRACK_SLOTS_DEF,
  parameter int unsigned FrameDet   = ctlc_pkg::FRAME_DET_DEF,
  parameter int unsigned CoordBits  = ctlc_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ctlc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [ctlc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [CoordBits-1:0]              box_left_i,
  input  wire logic [CoordBits-1:0]              box_top_i,
  input  wire logic [CoordBits-1:0]              box_right_i,
  input  wire logic [CoordBits-1:0]              box_bottom_i,
  input  wire logic [7:0]                        object_class_i,
  input  wire ctlc_pkg::ctlc_cmd_t               cmd_i,
  output ctlc_pkg::ctlc_status_t                 status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [31:0]                            entered_total_o,
  output logic [31:0]                            exited_total_o,
  output logic [5:0]                             live_tracks_o,
  output logic                                   detection_dropped_o,
  output logic                                   track_dropped_o
);
  import ctlc_pkg::*;

  localparam int unsigned SW   = CoordBits + 1;
  localparam int unsigned SAW  = TrackSlots > 1 ? $clog2(TrackSlots) : 1;
  localparam int unsigned SCW  = $clog2(TrackSlots + 1);
  localparam int unsigned CAW  = FrameDet > 1 ? $clog2(FrameDet) : 1;
  localparam int unsigned CCW  = $clog2(FrameDet + 1);
  localparam int unsigned CW   = (2 * SW + 1) > 26 ? (2 * SW + 1) : 26;
  localparam int unsigned LW   = SW > 13 ? SW : 13;
  localparam int unsigned RW   = 32 + 4 * SW + 8;
  localparam int unsigned CRW  = 2 * SW;
  // Slot record layout, lowest bits first: missed, prior y, prior x, y, x, identity.
  localparam int unsigned R_PY = 8;
  localparam int unsigned R_PX = 8 + SW;
  localparam int unsigned R_Y  = 8 + 2 * SW;
  localparam int unsigned R_X  = 8 + 3 * SW;
  localparam int unsigned R_ID = 8 + 4 * SW;

  // Configuration registers.
  logic [11:0] line_q, radius_q;
  logic [7:0]  max_missed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q       <= LINE_RST;
      max_missed_q <= MISSED_RST;
      radius_q     <= RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_LINE:       line_q       <= cfg_data_i;
        CFG_MAX_MISSED: max_missed_q <= cfg_data_i[7:0];
        CFG_RADIUS:     radius_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and bookkeeping state.
  logic [CCW-1:0]        cand_count_q, cidx_q;
  logic [FrameDet-1:0]   taken_q;
  logic [TrackSlots-1:0] live_q, done_q, vis_q;
  logic [SAW-1:0]        idx_q, best_slot_q;
  logic [SCW-1:0]        free_q, live_cnt_q;
  logic [31:0]           best_ident_q, ident_next_q, in_total_q, out_total_q;
  logic                  best_found_q, pick_found_q, drop_det_q, drop_trk_q, out_valid_q;
  logic [CAW-1:0]        pick_idx_q;

  // Payload registers.
  logic [RW-1:0]  rec_q;
  logic [SW-1:0]  dx_q, dy_q, cx_q, cy_q, pick_x_q, pick_y_q;
  logic [CRW-1:0] sqx_q, sqy_q;
  logic [CW-1:0]  limit_q, best_d_q;
  logic [31:0]    ent_o_q, ext_o_q;
  logic [5:0]     live_o_q;
  logic           dd_o_q, td_o_q;

  // Stores.
  logic           slot_we, slot_re, cand_we, cand_re;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  logic [RW-1:0]  slot_wdata, slot_rdata;
  logic [2*SW-1:0] cand_wdata, cand_rdata;

  ctlc_ram #(.Width(RW), .Depth(TrackSlots)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ctlc_ram #(.Width(2 * SW), .Depth(FrameDet)) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (cand_count_q[CAW-1:0]),
    .wdata_i (cand_wdata),
    .re_i    (cand_re),
    .raddr_i (cidx_q[CAW-1:0]),
    .rdata_o (cand_rdata)
  );

  logic            is_person, cand_full, idx_last, cand_end, cur_taken;
  logic            slot_full, slot_free;
  logic [SW-1:0]   rd_x, rd_px, c_x, c_y, rec_x, rec_y;
  logic [31:0]     rd_ident;
  logic [7:0]      rec_missed, new_missed;
  logic [CW-1:0]   sq_dist;
  logic [12:0]     radius2;
  logic [LW-1:0]   line2;
  logic            was_left, now_left;

  assign is_person  = object_class_i == PERSON_CLASS;
  assign cand_full  = cand_count_q >= CCW'(FrameDet);
  assign idx_last   = idx_q == SAW'(TrackSlots - 1);
  assign cand_end   = cidx_q >= cand_count_q;
  assign cur_taken  = taken_q[cidx_q[CAW-1:0]];
  assign slot_full  = free_q >= SCW'(TrackSlots);
  assign slot_free  = !slot_full && !live_q[free_q[SAW-1:0]];

  assign rd_ident   = slot_rdata[R_ID +: 32];
  assign rd_x       = slot_rdata[R_X +: SW];
  assign rd_px      = slot_rdata[R_PX +: SW];
  assign rec_x      = rec_q[R_X +: SW];
  assign rec_y      = rec_q[R_Y +: SW];
  assign rec_missed = rec_q[7:0];
  assign c_x        = cand_rdata[SW-1:0];
  assign c_y        = cand_rdata[2*SW-1:SW];

  assign cand_wdata = {{1'b0, box_top_i} + {1'b0, box_bottom_i},
                       {1'b0, box_left_i} + {1'b0, box_right_i}};
  assign cand_we    = cmd_i.det_load && is_person && !cand_full;
  assign cand_re    = cmd_i.c_rd || (cmd_i.nw_rd && !cur_taken);

  assign slot_re    = cmd_i.min_rd || cmd_i.cr_rd || cmd_i.match_start;
  assign slot_raddr = cmd_i.match_start ? best_slot_q : idx_q;
  assign slot_we    = cmd_i.mt_wb || (cmd_i.nw_free && slot_free);
  assign slot_waddr = cmd_i.mt_wb ? best_slot_q : free_q[SAW-1:0];

  assign new_missed = pick_found_q ? 8'd0 :
                      (rec_missed == MISSED_MAX ? MISSED_MAX : rec_missed + 8'd1);

  always_comb begin
    if (cmd_i.mt_wb) begin
      if (pick_found_q) begin
        slot_wdata = {rec_q[R_ID +: 32], pick_x_q, pick_y_q, rec_x, rec_y, new_missed};
      end else begin
        slot_wdata = {rec_q[RW-1:8], new_missed};
      end
    end else begin
      slot_wdata = {ident_next_q, c_x, c_y, c_x, c_y, 8'd0};
    end
  end

  assign sq_dist  = CW'(sqx_q) + CW'(sqy_q);
  assign radius2  = {radius_q, 1'b0};
  assign line2    = LW'({line_q, 1'b0});
  assign was_left = LW'(rd_px) < line2;
  assign now_left = LW'(rd_x) < line2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_start) limit_q <= CW'(radius2) * CW'(radius2);
    if (cmd_i.mt_rec) rec_q <= slot_rdata;
    if (cmd_i.c_diff) begin
      dx_q <= (rec_x >= c_x) ? rec_x - c_x : c_x - rec_x;
      dy_q <= (rec_y >= c_y) ? rec_y - c_y : c_y - rec_y;
      cx_q <= c_x;
      cy_q <= c_y;
    end
    if (cmd_i.c_mul) begin
      sqx_q <= dx_q * dx_q;
      sqy_q <= dy_q * dy_q;
    end
    if (cmd_i.match_start) best_d_q <= limit_q;
    if (cmd_i.c_cmp && !cur_taken && sq_dist < best_d_q) begin
      best_d_q   <= sq_dist;
      pick_idx_q <= cidx_q[CAW-1:0];
      pick_x_q   <= cx_q;
      pick_y_q   <= cy_q;
    end
    if (cmd_i.min_cmp && live_q[idx_q] && !vis_q[idx_q] &&
        (!best_found_q || rd_ident < best_ident_q)) begin
      best_ident_q <= rd_ident;
      best_slot_q  <= idx_q;
    end
    if (cmd_i.result_load) begin
      ent_o_q  <= in_total_q;
      ext_o_q  <= out_total_q;
      live_o_q <= 6'(live_cnt_q);
      dd_o_q   <= drop_det_q;
      td_o_q   <= drop_trk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_count_q <= '0;
      cidx_q       <= '0;
      taken_q      <= '0;
      live_q       <= '0;
      done_q       <= '0;
      vis_q        <= '0;
      idx_q        <= '0;
      free_q       <= '0;
      live_cnt_q   <= '0;
      ident_next_q <= 32'd1;
      in_total_q   <= '0;
      out_total_q  <= '0;
      best_found_q <= 1'b0;
      pick_found_q <= 1'b0;
      drop_det_q   <= 1'b0;
      drop_trk_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.det_load && is_person) begin
        if (cand_full) drop_det_q <= 1'b1;
        else cand_count_q <= cand_count_q + CCW'(1);
      end
      if (cmd_i.clear_all) begin
        cand_count_q <= '0;
        taken_q      <= '0;
        live_q       <= '0;
        ident_next_q <= 32'd1;
        in_total_q   <= '0;
        out_total_q  <= '0;
        drop_det_q   <= 1'b0;
        drop_trk_q   <= 1'b0;
      end
      if (cmd_i.frame_start) begin
        vis_q        <= '0;
        best_found_q <= 1'b0;
        idx_q        <= '0;
      end
      if (cmd_i.min_cmp) begin
        if (live_q[idx_q] && !vis_q[idx_q] &&
            (!best_found_q || rd_ident < best_ident_q)) begin
          best_found_q <= 1'b1;
        end
        idx_q <= idx_last ? '0 : idx_q + SAW'(1);
      end
      if (cmd_i.match_start) begin
        vis_q[best_slot_q] <= 1'b1;
        cidx_q             <= '0;
        pick_found_q       <= 1'b0;
      end
      if (cmd_i.c_cmp) begin
        if (!cur_taken && sq_dist < best_d_q) pick_found_q <= 1'b1;
        cidx_q <= cidx_q + CCW'(1);
      end
      if (cmd_i.mt_wb) begin
        best_found_q <= 1'b0;
        if (pick_found_q) taken_q[pick_idx_q] <= 1'b1;
        if (new_missed > max_missed_q) live_q[best_slot_q] <= 1'b0;
      end
      if (cmd_i.nw_init) begin
        cidx_q     <= '0;
        free_q     <= '0;
        idx_q      <= '0;
        live_cnt_q <= '0;
      end
      if (cmd_i.nw_rd && cur_taken) cidx_q <= cidx_q + CCW'(1);
      if (cmd_i.nw_free) begin
        if (slot_full) begin
          drop_trk_q <= 1'b1;
          cidx_q     <= cidx_q + CCW'(1);
        end else if (slot_free) begin
          live_q[free_q[SAW-1:0]] <= 1'b1;
          done_q[free_q[SAW-1:0]] <= 1'b0;
          ident_next_q            <= ident_next_q + 32'd1;
          cidx_q                  <= cidx_q + CCW'(1);
        end else begin
          free_q <= free_q + SCW'(1);
        end
      end
      if (cmd_i.cr_chk) begin
        if (live_q[idx_q]) begin
          live_cnt_q <= live_cnt_q + SCW'(1);
          if (!done_q[idx_q] && (was_left != now_left)) begin
            done_q[idx_q] <= 1'b1;
            if (was_left) in_total_q <= in_total_q + 32'd1;
            else out_total_q <= out_total_q + 32'd1;
          end
        end
        idx_q <= idx_last ? '0 : idx_q + SAW'(1);
      end
      if (cmd_i.result_load) begin
        out_valid_q  <= 1'b1;
        cand_count_q <= '0;
        taken_q      <= '0;
        drop_det_q   <= 1'b0;
        drop_trk_q   <= 1'b0;
      end
    end
  end

  assign status_o.best_found = best_found_q;
  assign status_o.idx_last   = idx_last;
  assign status_o.cand_end   = cand_end;
  assign status_o.cand_taken = cur_taken;
  assign status_o.slot_full  = slot_full;
  assign status_o.slot_free  = slot_free;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign entered_total_o     = ent_o_q;
  assign exited_total_o      = ext_o_q;
  assign live_tracks_o       = live_o_q;
  assign detection_dropped_o = dd_o_q;
  assign track_dropped_o     = td_o_q;

  a_cand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_count_q <= CCW'(FrameDet))
    else $error("candidate count beyond buffer depth");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.result_load))
    else $error("result raised without a frame end");

  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mt_wb && pick_found_q) |-> (CCW'(pick_idx_q) < cand_count_q))
    else $error("matched candidate outside the filled buffer");

endmodule
`default_nettype wire

/* design/ctlc_ctrl.sv */
// Controller state machine that sequences detection loads, clears and the frame-end passes.
`default_nettype none
module ctlc_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [1:0]             action_i,
  output logic                        in_ready_o,
  input  wire ctlc_pkg::ctlc_status_t status_i,
  output ctlc_pkg::ctlc_cmd_t         cmd_o
);
  import ctlc_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_MIN_RD  = 15'b000000000000010,
    S_MIN_CMP = 15'b000000000000100,
    S_MIN_END = 15'b000000000001000,
    S_MT_REC  = 15'b000000000010000,
    S_C_RD    = 15'b000000000100000,
    S_C_DIFF  = 15'b000000001000000,
    S_C_MUL   = 15'b000000010000000,
    S_C_CMP   = 15'b000000100000000,
    S_MT_WB   = 15'b000001000000000,
    S_NW_RD   = 15'b000010000000000,
    S_NW_FREE = 15'b000100000000000,
    S_CR_RD   = 15'b001000000000000,
    S_CR_CHK  = 15'b010000000000000,
    S_RESULT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_DETECT: cmd_o.det_load = 1'b1;
            ACT_CLEAR:  cmd_o.clear_all = 1'b1;
            ACT_FRAME_END: begin
              cmd_o.frame_start = 1'b1;
              state_d           = S_MIN_RD;
            end
            default: ;
          endcase
        end
      end
      S_MIN_RD: begin
        cmd_o.min_rd = 1'b1;
        state_d      = S_MIN_CMP;
      end
      S_MIN_CMP: begin
        cmd_o.min_cmp = 1'b1;
        state_d       = status_i.idx_last ? S_MIN_END : S_MIN_RD;
      end
      S_MIN_END: begin
        if (status_i.best_found) begin
          cmd_o.match_start = 1'b1;
          state_d           = S_MT_REC;
        end else begin
          cmd_o.nw_init = 1'b1;
          state_d       = S_NW_RD;
        end
      end
      S_MT_REC: begin
        cmd_o.mt_rec = 1'b1;
        state_d      = S_C_RD;
      end
      S_C_RD: begin
        if (status_i.cand_end) begin
          state_d = S_MT_WB;
        end else begin
          cmd_o.c_rd = 1'b1;
          state_d    = S_C_DIFF;
        end
      end
      S_C_DIFF: begin
        cmd_o.c_diff = 1'b1;
        state_d      = S_C_MUL;
      end
      S_C_MUL: begin
        cmd_o.c_mul = 1'b1;
        state_d     = S_C_CMP;
      end
      S_C_CMP: begin
        cmd_o.c_cmp = 1'b1;
        state_d     = S_C_RD;
      end
      S_MT_WB: begin
        cmd_o.mt_wb = 1'b1;
        state_d     = S_MIN_RD;
      end
      S_NW_RD: begin
        if (status_i.cand_end) begin
          state_d = S_CR_RD;
        end else begin
          cmd_o.nw_rd = 1'b1;
          if (!status_i.cand_taken) state_d = S_NW_FREE;
        end
      end
      S_NW_FREE: begin
        cmd_o.nw_free = 1'b1;
        if (status_i.slot_full || status_i.slot_free) state_d = S_NW_RD;
      end
      S_CR_RD: begin
        cmd_o.cr_rd = 1'b1;
        state_d     = S_CR_CHK;
      end
      S_CR_CHK: begin
        cmd_o.cr_chk = 1'b1;
        state_d      = status_i.idx_last ? S_RESULT : S_CR_RD;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/centroid_tracker_line_counter.sv */
// Top level of the centroid tracker with vertical line crossing counter.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/s_axis_tready tuser: action; tdata: box, class
//  m_axis    out        m_axis_tvalid/m_axis_tready tdata: totals, live count, drop flags
//  cfg       in         cfg_we_i (no wait)          cfg_addr_i, cfg_data_i
//
// A detection, clear or unused action transfer leaves the block idle, so it stays ready
// for the next transfer. A frame end walks the track table once per live track, plus a
// final pass, reading and comparing every slot to find the next identity in order; for
// each live track it reads, differences, squares and compares every candidate, then
// it opens new tracks and checks crossings over every slot.
// Reset is asynchronous and active low; the stores need no clearing pass since
// every entry is guarded by valid flags or the candidate count.
// The finished result sits in an output register, so detections of the next frame
// are taken while it waits; a second frame end stalls only in its final step.
`default_nettype none
module centroid_tracker_line_counter #(
  parameter int unsigned TrackSlots = ctlc_pkg::TRACK_SLOTS_DEF,
  parameter int unsigned FrameDet   = ctlc_pkg::FRAME_DET_DEF,
  parameter int unsigned CoordBits  = ctlc_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata, lowest bit up: box_left, box_top, box_right, box_bottom, object_class.
  input  wire logic [((4*CoordBits+8+7)/8)*8-1:0] s_axis_tdata,
  // tuser: action.
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata, lowest bit up: entered_total, exited_total, live_tracks,
  // detection_dropped, track_dropped.
  output logic [71:0]                          m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [ctlc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ctlc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ctlc_pkg::*;

  ctlc_cmd_t    cmd;
  ctlc_status_t status;
  logic [31:0]  entered_total, exited_total;
  logic [5:0]   live_tracks;
  logic         detection_dropped, track_dropped;

  ctlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ctlc_datapath #(
    .TrackSlots (TrackSlots),
    .FrameDet   (FrameDet),
    .CoordBits  (CoordBits)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_data_i          (cfg_data_i),
    .box_left_i          (s_axis_tdata[0 +: CoordBits]),
    .box_top_i           (s_axis_tdata[CoordBits +: CoordBits]),
    .box_right_i         (s_axis_tdata[2*CoordBits +: CoordBits]),
    .box_bottom_i        (s_axis_tdata[3*CoordBits +: CoordBits]),
    .object_class_i      (s_axis_tdata[4*CoordBits +: 8]),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .entered_total_o     (entered_total),
    .exited_total_o      (exited_total),
    .live_tracks_o       (live_tracks),
    .detection_dropped_o (detection_dropped),
    .track_dropped_o     (track_dropped)
  );

  assign m_axis_tdata = {track_dropped, detection_dropped, live_tracks,
                         exited_total, entered_total};

endmodule
`default_nettype wire
